// ===== design/ssmcd_pkg.sv =====
// Shared types, codes and the sample-to-distance table of the command decoder.
package ssmcd_pkg;

  localparam int LIMIT_W = 10;
  localparam int DIST_W = 15;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd800;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_TX = 2'd0;
  localparam logic [1:0] KIND_REQ = 2'd1;
  localparam logic [1:0] KIND_MOTOR = 2'd2;

  localparam logic [3:0] DIR_FWD = 4'h6;
  localparam logic [3:0] DIR_REV = 4'h9;
  localparam logic [3:0] DIR_SPIN_R = 4'h5;
  localparam logic [3:0] DIR_SPIN_L = 4'hA;
  localparam logic [3:0] DIR_STOP = 4'h0;

  localparam logic [31:0] DIST_TOP = 32'd27996;
  localparam logic [63:0] EXP_NUM = 64'd11546;
  localparam logic [63:0] EXP_DEN = 64'd10000;

  typedef enum logic [1:0] {
    OP_REQUEST,
    OP_ECHO,
    OP_DISTANCE,
    OP_MOTOR
  } ssmcd_op_t;

  typedef struct packed {
    ssmcd_op_t          op;
    logic [3:0]         chan;
    logic [7:0]         byte_a;
    logic [7:0]         byte_b;
    logic [3:0]         dir;
    logic               dir_valid;
    logic [LIMIT_W-1:0] distance;
  } ssmcd_cmd_t;

  typedef struct packed {
    logic [1:0] kind_out;
    logic [7:0] tx_byte;
    logic [3:0] adc_channel;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [3:0] direction;
    logic       direction_valid;
    logic       last;
  } ssmcd_result_t;

  typedef logic [255:0][DIST_W-1:0] ssmcd_dist_tab_t;

  // Base-two logarithm with 30 fraction bits, one bit per squaring step.
  function automatic logic [63:0] log2_fix(input logic [31:0] v);
    logic [63:0] m;
    logic [63:0] r;
    int n;
    int k;
    int i;
    n = 0;
    for (k = 0; k < 30; k++) begin
      if ((v >> (k + 1)) != 32'd0) begin
        n = k + 1;
      end
    end
    m = 64'(v) << (30 - n);
    r = 64'(n) << 30;
    for (i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    if (v == 32'd0) begin
      r = 64'd0;
    end
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] distance_of(input logic [31:0] x);
    logic [63:0] y;
    logic [63:0] top;
    logic [63:0] z;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    int it;
    y = log2_fix(x) * EXP_NUM / EXP_DEN;
    top = log2_fix(DIST_TOP);
    z = top - y;
    lo = 32'd1;
    hi = DIST_TOP;
    for (it = 0; it < 16; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 32'd1) >> 1;
        if (log2_fix(mid) <= z) begin
          lo = mid;
        end else begin
          hi = mid - 32'd1;
        end
      end
    end
    if (y >= top) begin
      lo = 32'd1;
    end
    return DIST_W'(lo);
  endfunction

  function automatic ssmcd_dist_tab_t build_dist_tab();
    ssmcd_dist_tab_t t;
    int x;
    t = '0;
    for (x = 1; x < 256; x++) begin
      t[x] = distance_of(32'(x));
    end
    return t;
  endfunction

  localparam ssmcd_dist_tab_t DIST_TABLE = build_dist_tab();

endpackage

// ===== design/ssmcd_queue.sv =====
// Short command queue between the front end and the back end.
module ssmcd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  ssmcd_pkg::ssmcd_cmd_t wr_data,
  output logic                q_full,
  input  logic                rd_en,
  output logic                q_valid,
  output ssmcd_pkg::ssmcd_cmd_t rd_data
);
  import ssmcd_pkg::*;

  ssmcd_cmd_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/ssmcd_front.sv =====
// Front end: takes input words, tracks parse state and queues commands.
module ssmcd_front #(
  parameter int NB = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic                               in_kind,
  input  logic [7:0]                         in_rx_byte,
  input  logic [7:0]                         in_adc_sample,
  input  logic [ssmcd_pkg::LIMIT_W-1:0]      limit,
  output logic                               q_push,
  output ssmcd_pkg::ssmcd_cmd_t              q_entry
);
  import ssmcd_pkg::*;

  localparam logic [7:0] BYTE_ECHO_FIRST = "a";
  localparam logic [7:0] BYTE_ECHO_LAST = "e";
  localparam logic [7:0] BYTE_DIST_S = "S";
  localparam logic [7:0] BYTE_DIST_T = "T";
  localparam logic [7:0] BYTE_DIST_U = "U";
  localparam logic [7:0] BYTE_MOTOR = "m";
  localparam logic [7:0] BYTE_SEP = "#";
  localparam logic [7:0] BYTE_END = "!";
  localparam logic [7:0] BYTE_PLUS = "+";
  localparam logic [7:0] BYTE_MINUS = "-";
  localparam logic [7:0] BYTE_ZERO = "0";
  localparam logic [7:0] BYTE_NINE = "9";
  localparam logic [7:0] BYTE_SPACE = " ";
  localparam logic [7:0] ECHO_CHAN_OFS = 8'h5D;
  localparam logic [3:0] CHAN_S = 4'd11;
  localparam logic [3:0] CHAN_T = 4'd9;
  localparam logic [3:0] CHAN_U = 4'd13;

  typedef enum logic [1:0] {
    SCAN_SKIP,
    SCAN_DIGITS,
    SCAN_DONE
  } scan_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_ECHO,
    PEND_DIST
  } pend_t;

  typedef struct packed {
    logic [NB-1:0] val;
    logic          neg;
    scan_t         scan;
  } num_t;

  localparam num_t NUM_CLEAR = '{val: '0, neg: 1'b0, scan: SCAN_SKIP};

  function automatic num_t feed(input num_t cur, input logic [7:0] b);
    num_t          res;
    logic          digit;
    logic [NB-1:0] acc;
    res   = cur;
    digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
    acc   = cur.val * NB'(10) + NB'(b[3:0]);
    if (b != 8'd0) begin
      case (cur.scan)
        SCAN_SKIP: begin
          if (b inside {[8'd9:8'd13], BYTE_SPACE}) begin
            res = cur;
          end else if (b == BYTE_PLUS || b == BYTE_MINUS) begin
            res.neg  = cur.neg || (b == BYTE_MINUS);
            res.scan = SCAN_DIGITS;
          end else if (digit) begin
            res.scan = SCAN_DIGITS;
            res.val  = acc;
          end else begin
            res.scan = SCAN_DONE;
          end
        end
        SCAN_DIGITS: begin
          if (digit) begin
            res.val = acc;
          end else begin
            res.scan = SCAN_DONE;
          end
        end
        default: res = cur;
      endcase
    end
    return res;
  endfunction

  logic               phase_r;
  logic               phase_nxt;
  logic               incoming_r;
  logic               incoming_nxt;
  num_t               first_r;
  num_t               first_nxt;
  num_t               second_r;
  num_t               second_nxt;
  pend_t              pend_r;
  pend_t              pend_nxt;

  logic [7:0]         b;
  num_t               first_use;
  logic [NB-1:0]      a_val;
  logic [NB-1:0]      c_val;
  logic               a_neg;
  logic               a_zero;
  logic               a_pos;
  logic               c_neg;
  logic               c_zero;
  logic               c_pos;
  logic [3:0]         dir_val;
  logic               dir_ok;
  logic [DIST_W-1:0]  tab_val;
  logic [LIMIT_W-1:0] dist_val;

  assign b = in_rx_byte;

  always_comb begin
    first_use = first_r;
    if (incoming_r && !phase_r && b != BYTE_MOTOR) begin
      first_use = feed(first_r, b);
    end
    a_val  = first_use.neg ? NB'('0) - first_use.val : first_use.val;
    c_val  = second_r.neg ? NB'('0) - second_r.val : second_r.val;
    a_neg  = a_val[NB-1];
    a_zero = (a_val == '0);
    a_pos  = !a_neg && !a_zero;
    c_neg  = c_val[NB-1];
    c_zero = (c_val == '0);
    c_pos  = !c_neg && !c_zero;
    dir_ok = 1'b1;
    if (a_pos && c_pos) begin
      dir_val = DIR_FWD;
    end else if (a_neg && c_pos) begin
      dir_val = DIR_SPIN_L;
    end else if (a_pos && c_neg) begin
      dir_val = DIR_SPIN_R;
    end else if (a_neg && c_neg) begin
      dir_val = DIR_REV;
    end else begin
      dir_val = DIR_STOP;
      dir_ok  = a_zero && c_zero;
    end
  end

  always_comb begin
    tab_val = DIST_TABLE[in_adc_sample];
    if (in_adc_sample == 8'd0 || tab_val > DIST_W'(limit)) begin
      dist_val = limit;
    end else begin
      dist_val = tab_val[LIMIT_W-1:0];
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    incoming_nxt = incoming_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    pend_nxt     = pend_r;
    q_push       = 1'b0;
    q_entry      = '0;
    if (accept) begin
      if (in_kind) begin
        case (pend_r)
          PEND_ECHO: begin
            q_push         = 1'b1;
            q_entry.op     = OP_ECHO;
            q_entry.byte_a = in_adc_sample;
          end
          PEND_DIST: begin
            q_push           = 1'b1;
            q_entry.op       = OP_DISTANCE;
            q_entry.distance = dist_val;
          end
          default: q_push = 1'b0;
        endcase
        pend_nxt = PEND_NONE;
      end else begin
        if (b inside {[BYTE_ECHO_FIRST:BYTE_ECHO_LAST]}) begin
          q_push       = 1'b1;
          q_entry.op   = OP_REQUEST;
          q_entry.chan = 4'(b - ECHO_CHAN_OFS);
          pend_nxt     = PEND_ECHO;
        end else if (b == BYTE_DIST_S || b == BYTE_DIST_T || b == BYTE_DIST_U) begin
          q_push       = 1'b1;
          q_entry.op   = OP_REQUEST;
          q_entry.chan = (b == BYTE_DIST_S) ? CHAN_S : ((b == BYTE_DIST_T) ? CHAN_T : CHAN_U);
          pend_nxt     = PEND_DIST;
        end
        if (b == BYTE_MOTOR) begin
          incoming_nxt = 1'b1;
        end
        first_nxt = first_use;
        if (b == BYTE_SEP) begin
          phase_nxt = 1'b1;
        end
        if (b == BYTE_END) begin
          q_push            = 1'b1;
          q_entry.op        = OP_MOTOR;
          q_entry.byte_a    = a_val[7:0];
          q_entry.byte_b    = c_val[7:0];
          q_entry.dir       = dir_val;
          q_entry.dir_valid = dir_ok;
          phase_nxt         = 1'b0;
          incoming_nxt      = 1'b0;
          first_nxt         = NUM_CLEAR;
          second_nxt        = NUM_CLEAR;
        end
        if (phase_nxt && b != BYTE_SEP) begin
          second_nxt = feed(second_r, b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= 1'b0;
      incoming_r <= 1'b0;
      first_r    <= NUM_CLEAR;
      second_r   <= NUM_CLEAR;
      pend_r     <= PEND_NONE;
    end else begin
      phase_r    <= phase_nxt;
      incoming_r <= incoming_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

// ===== design/ssmcd_back.sv =====
// Back end: expands queued commands into result words in the output register.
module ssmcd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  ssmcd_pkg::ssmcd_cmd_t    q_entry,
  output logic                     q_pop,
  input  logic                     res_pop,
  output logic                     res_valid,
  output ssmcd_pkg::ssmcd_result_t res_data
);
  import ssmcd_pkg::*;

  logic          valid_r;
  logic          valid_nxt;
  logic          second_r;
  logic          second_nxt;
  logic [7:0]    low_r;
  logic [7:0]    low_nxt;
  ssmcd_result_t res_r;
  ssmcd_result_t res_nxt;
  ssmcd_result_t res_new;
  logic          out_load;

  assign res_valid = valid_r;
  assign res_data  = res_r;
  assign out_load  = !valid_r || res_pop;
  assign q_pop     = out_load && !second_r && q_valid;

  always_comb begin
    res_new      = '0;
    res_new.last = 1'b1;
    case (q_entry.op)
      OP_REQUEST: begin
        res_new.kind_out    = KIND_REQ;
        res_new.adc_channel = q_entry.chan;
      end
      OP_ECHO: begin
        res_new.kind_out = KIND_TX;
        res_new.tx_byte  = q_entry.byte_a;
      end
      OP_DISTANCE: begin
        res_new.kind_out = KIND_TX;
        res_new.tx_byte  = 8'(q_entry.distance[LIMIT_W-1:8]);
        res_new.last     = 1'b0;
      end
      OP_MOTOR: begin
        res_new.kind_out        = KIND_MOTOR;
        res_new.left_speed      = q_entry.byte_a;
        res_new.right_speed     = q_entry.byte_b;
        res_new.direction       = q_entry.dir;
        res_new.direction_valid = q_entry.dir_valid;
      end
      default: res_new = '0;
    endcase
  end

  always_comb begin
    valid_nxt  = valid_r && !res_pop;
    second_nxt = second_r;
    low_nxt    = low_r;
    res_nxt    = res_r;
    if (out_load) begin
      if (second_r) begin
        res_nxt          = '0;
        res_nxt.kind_out = KIND_TX;
        res_nxt.tx_byte  = low_r;
        res_nxt.last     = 1'b1;
        valid_nxt        = 1'b1;
        second_nxt       = 1'b0;
      end else if (q_valid) begin
        res_nxt    = res_new;
        valid_nxt  = 1'b1;
        second_nxt = (q_entry.op == OP_DISTANCE);
        low_nxt    = q_entry.distance[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    low_r <= low_nxt;
  end

endmodule

// ===== design/serial_sensor_motor_command_decoder_core.sv =====
// Top level of the serial sensor and motor command decoder.
//
//   channel  handshake              contents
//   in       push / full            in_kind, in_rx_byte, in_adc_sample
//   out      pop / empty            kind_out, tx_byte, channel, speeds, direction, last
//   cfg      cfg_valid / cfg_ready  cfg_data: distance limit
//
// One word is taken per cycle while full is low; every word is parsed in the cycle
// it is taken. A result passes the command queue and the output register on its way
// to the ports; that register sends one result per cycle while pop is high, so a
// distance answer holds the back end while the two-entry command queue takes words.
// Reset is synchronous and needs no clearing pass; the limit returns to 800.
// A stalled output fills the queue, and then full holds the input side.
module serial_sensor_motor_command_decoder_core #(
  parameter int NUMBER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_kind,
  input  logic [7:0]                    in_rx_byte,
  input  logic [7:0]                    in_adc_sample,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_kind_out,
  output logic [7:0]                    out_tx_byte,
  output logic [3:0]                    out_adc_channel,
  output logic [7:0]                    out_left_speed,
  output logic [7:0]                    out_right_speed,
  output logic [3:0]                    out_direction,
  output logic                          out_direction_valid,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssmcd_pkg::LIMIT_W-1:0] cfg_data
);
  import ssmcd_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] limit_nxt;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_valid;
  ssmcd_cmd_t         q_wr_entry;
  ssmcd_cmd_t         q_rd_entry;
  logic               res_valid;
  ssmcd_result_t      res_data;
  logic               in_accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign in_accept = push && !q_full;
  assign limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  ssmcd_front #(
    .NB(NUMBER_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .in_kind      (in_kind),
    .in_rx_byte   (in_rx_byte),
    .in_adc_sample(in_adc_sample),
    .limit        (limit_r),
    .q_push       (q_push),
    .q_entry      (q_wr_entry)
  );

  ssmcd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_data(q_wr_entry),
    .q_full (q_full),
    .rd_en  (q_pop),
    .q_valid(q_valid),
    .rd_data(q_rd_entry)
  );

  ssmcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_rd_entry),
    .q_pop    (q_pop),
    .res_pop  (pop),
    .res_valid(res_valid),
    .res_data (res_data)
  );

  assign empty               = !res_valid;
  assign out_kind_out        = res_data.kind_out;
  assign out_tx_byte         = res_data.tx_byte;
  assign out_adc_channel     = res_data.adc_channel;
  assign out_left_speed      = res_data.left_speed;
  assign out_right_speed     = res_data.right_speed;
  assign out_direction       = res_data.direction;
  assign out_direction_valid = res_data.direction_valid;
  assign out_last            = res_data.last;

`ifndef SYNTHESIS
  a_first_byte_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> (out_kind_out == KIND_TX))
    else $error("non-final result is not a transmit word");

  a_low_byte_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last) |=> (!empty && out_last && out_kind_out == KIND_TX))
    else $error("distance low byte did not follow its high byte");

  a_dir_clear_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_direction_valid) |-> (out_direction == DIR_STOP))
    else $error("direction set without a matching sign case");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the serial sensor and motor command decoder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssmcd_pkg::*;

  localparam int NUMBER_BITS = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CAP = 100000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES = 8;

  localparam logic [7:0] CMD_ECHO_FIRST = "a";
  localparam logic [7:0] CMD_ECHO_LAST = "e";
  localparam logic [7:0] CMD_RANGE_S = "S";
  localparam logic [7:0] CMD_RANGE_T = "T";
  localparam logic [7:0] CMD_RANGE_U = "U";
  localparam logic [7:0] CMD_TEXT_START = "m";
  localparam logic [7:0] CMD_SECOND_FIELD = "#";
  localparam logic [7:0] CMD_MOTOR_END = "!";
  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CHR_TAB = 8'h09;
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_SPACE = " ";
  localparam logic [7:0] CHR_PLUS = "+";
  localparam logic [7:0] CHR_MINUS = "-";
  localparam logic [7:0] CHR_ZERO = "0";
  localparam logic [7:0] CHR_NINE = "9";

  localparam logic [3:0] CHAN_ECHO_BASE = 4'd4;
  localparam logic [3:0] CHAN_RANGE_S = 4'd11;
  localparam logic [3:0] CHAN_RANGE_T = 4'd9;
  localparam logic [3:0] CHAN_RANGE_U = 4'd13;

  typedef enum logic [1:0] {SCAN_SKIP, SCAN_DIGITS, SCAN_DONE} scan_t;
  typedef enum logic [1:0] {AWAIT_NONE, AWAIT_ECHO, AWAIT_RANGE} await_t;

  typedef struct packed {
    logic [NUMBER_BITS-1:0] value;
    logic                   negative;
    scan_t                  scan;
  } number_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic in_kind = 1'b0;
  logic [7:0] in_rx_byte = 8'd0;
  logic [7:0] in_adc_sample = 8'd0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  logic full;
  logic empty;
  logic [1:0] out_kind_out;
  logic [7:0] out_tx_byte;
  logic [3:0] out_adc_channel;
  logic [7:0] out_left_speed;
  logic [7:0] out_right_speed;
  logic [3:0] out_direction;
  logic out_direction_valid;
  logic out_last;
  logic cfg_ready;

  ssmcd_result_t expected_replies[$];
  logic [DIST_W-1:0] range_table [256];
  logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;
  logic in_second_field = 1'b0;
  logic text_enabled = 1'b0;
  number_t first_number = '0;
  number_t second_number = '0;
  await_t awaiting = AWAIT_NONE;
  int error_count = 0;
  int reply_count = 0;
  int items_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  serial_sensor_motor_command_decoder_core #(
    .NUMBER_BITS(NUMBER_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_kind(in_kind),
    .in_rx_byte(in_rx_byte),
    .in_adc_sample(in_adc_sample),
    .empty(empty),
    .pop(pop),
    .out_kind_out(out_kind_out),
    .out_tx_byte(out_tx_byte),
    .out_adc_channel(out_adc_channel),
    .out_left_speed(out_left_speed),
    .out_right_speed(out_right_speed),
    .out_direction(out_direction),
    .out_direction_valid(out_direction_valid),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [63:0] fixed_log2(input logic [31:0] v);
    logic [63:0] mant;
    logic [63:0] res;
    int top_bit;
    int k;
    if (v == 32'd0) begin
      return 64'd0;
    end
    top_bit = 0;
    for (k = 0; k < 32; k++) begin
      if (v[k]) begin
        top_bit = k;
      end
    end
    mant = 64'(v) << (30 - top_bit);
    res = 64'(top_bit) << 30;
    for (k = 29; k >= 0; k--) begin
      mant = (mant * mant) >> 30;
      if (mant >= 64'h8000_0000) begin
        mant = mant >> 1;
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [DIST_W-1:0] range_of(input logic [31:0] x);
    logic [63:0] y;
    logic [63:0] top;
    logic [63:0] z;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    y = fixed_log2(x) * EXP_NUM / EXP_DEN;
    top = fixed_log2(DIST_TOP);
    if (y >= top) begin
      return DIST_W'(1);
    end
    z = top - y;
    lo = 32'd1;
    hi = DIST_TOP;
    while (lo < hi) begin
      mid = (lo + hi + 32'd1) >> 1;
      if (fixed_log2(mid) <= z) begin
        lo = mid;
      end else begin
        hi = mid - 32'd1;
      end
    end
    return DIST_W'(lo);
  endfunction

  function automatic number_t feed_number(input number_t n, input logic [7:0] b);
    logic is_digit;
    is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
    if (b == CHR_NUL) begin
      return n;
    end
    if (n.scan == SCAN_SKIP) begin
      if ((b >= CHR_TAB && b <= CHR_CR) || b == CHR_SPACE) begin
        return n;
      end
      if (b == CHR_PLUS || b == CHR_MINUS) begin
        if (b == CHR_MINUS) begin
          n.negative = 1'b1;
        end
        n.scan = SCAN_DIGITS;
        return n;
      end
      n.scan = is_digit ? SCAN_DIGITS : SCAN_DONE;
    end else if (n.scan != SCAN_DIGITS) begin
      return n;
    end else if (!is_digit) begin
      n.scan = SCAN_DONE;
      return n;
    end
    if (is_digit) begin
      n.value = NUMBER_BITS'(n.value * 10 + (b - CHR_ZERO));
    end
    return n;
  endfunction

  function automatic logic signed [NUMBER_BITS-1:0] signed_number(input number_t n);
    return n.negative ? -n.value : n.value;
  endfunction

  function automatic ssmcd_result_t make_reply(input logic [1:0] kind, input logic [7:0] tx,
                                               input logic [3:0] chan, input logic is_last);
    ssmcd_result_t r;
    r = '0;
    r.kind_out = kind;
    r.tx_byte = tx;
    r.adc_channel = chan;
    r.last = is_last;
    return r;
  endfunction

  function automatic void decode_command(input logic is_adc, input logic [7:0] b,
                                         input logic [7:0] adc);
    ssmcd_result_t motor;
    logic [DIST_W-1:0] range_val;
    logic signed [NUMBER_BITS-1:0] left_num;
    logic signed [NUMBER_BITS-1:0] right_num;
    if (is_adc) begin
      if (awaiting == AWAIT_ECHO) begin
        expected_replies.push_back(make_reply(KIND_TX, adc, 4'd0, 1'b1));
      end else if (awaiting == AWAIT_RANGE) begin
        range_val = (adc == 8'd0) ? DIST_W'(limit_now) : range_table[adc];
        if (range_val > DIST_W'(limit_now)) begin
          range_val = DIST_W'(limit_now);
        end
        expected_replies.push_back(make_reply(KIND_TX, 8'(range_val >> 8), 4'd0, 1'b0));
        expected_replies.push_back(make_reply(KIND_TX, range_val[7:0], 4'd0, 1'b1));
      end
      awaiting = AWAIT_NONE;
      return;
    end
    if (b >= CMD_ECHO_FIRST && b <= CMD_ECHO_LAST) begin
      expected_replies.push_back(make_reply(KIND_REQ, 8'd0,
                                            CHAN_ECHO_BASE + 4'(b - CMD_ECHO_FIRST), 1'b1));
      awaiting = AWAIT_ECHO;
    end else if (b == CMD_RANGE_S || b == CMD_RANGE_T || b == CMD_RANGE_U) begin
      expected_replies.push_back(make_reply(KIND_REQ, 8'd0,
                                            (b == CMD_RANGE_S) ? CHAN_RANGE_S :
                                            (b == CMD_RANGE_T) ? CHAN_RANGE_T : CHAN_RANGE_U,
                                            1'b1));
      awaiting = AWAIT_RANGE;
    end
    if (b == CMD_TEXT_START) begin
      text_enabled = 1'b1;
    end
    if (text_enabled && !in_second_field && b != CMD_TEXT_START) begin
      first_number = feed_number(first_number, b);
    end
    if (b == CMD_SECOND_FIELD) begin
      in_second_field = 1'b1;
    end
    if (b == CMD_MOTOR_END) begin
      left_num = signed_number(first_number);
      right_num = signed_number(second_number);
      in_second_field = 1'b0;
      text_enabled = 1'b0;
      motor = make_reply(KIND_MOTOR, 8'd0, 4'd0, 1'b1);
      motor.left_speed = left_num[7:0];
      motor.right_speed = right_num[7:0];
      motor.direction_valid = 1'b1;
      if (left_num > 0 && right_num > 0) begin
        motor.direction = DIR_FWD;
      end else if (left_num < 0 && right_num > 0) begin
        motor.direction = DIR_SPIN_L;
      end else if (left_num > 0 && right_num < 0) begin
        motor.direction = DIR_SPIN_R;
      end else if (left_num < 0 && right_num < 0) begin
        motor.direction = DIR_REV;
      end else if (left_num == 0 && right_num == 0) begin
        motor.direction = DIR_STOP;
      end else begin
        motor.direction = '0;
        motor.direction_valid = 1'b0;
      end
      expected_replies.push_back(motor);
      first_number = '0;
      second_number = '0;
    end
    if (in_second_field && b != CMD_SECOND_FIELD) begin
      second_number = feed_number(second_number, b);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("reply %0d: %s is %0h, expected %0h",
                                reply_count, name, got, want));
    end
  endtask

  task automatic check_reply();
    ssmcd_result_t want;
    reply_count++;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("reply %0d arrived with none expected", reply_count));
    end else begin
      want = expected_replies.pop_front();
      check_field("kind_out", 8'(out_kind_out), 8'(want.kind_out));
      check_field("tx_byte", out_tx_byte, want.tx_byte);
      check_field("adc_channel", 8'(out_adc_channel), 8'(want.adc_channel));
      check_field("left_speed", out_left_speed, want.left_speed);
      check_field("right_speed", out_right_speed, want.right_speed);
      check_field("direction", 8'(out_direction), 8'(want.direction));
      check_field("direction_valid", 8'(out_direction_valid), 8'(want.direction_valid));
      check_field("last", 8'(out_last), 8'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && pop && empty === 1'b0) begin
      check_reply();
    end
    pop <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input logic kind, input logic [7:0] rx, input logic [7:0] adc);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_kind <= kind;
    in_rx_byte <= rx;
    in_adc_sample <= adc;
    do @(posedge clk); while (full !== 1'b0);
    decode_command(kind, rx, adc);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b, 8'($urandom_range(255)));
  endtask

  task automatic send_adc(input logic [7:0] v);
    send_word(1'b1, 8'($urandom_range(255)), v);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic wait_until_drained();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (expected_replies.size() != 0 && guard < DRAIN_CAP) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
      expected_replies.delete();
    end
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    wait_until_drained();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    limit_now = v;
  endtask

  task automatic send_request_sequence();
    int k;
    int r;
    k = $urandom_range(7);
    if (k < 5) begin
      send_byte(CMD_ECHO_FIRST + 8'(k));
    end else begin
      send_byte((k == 5) ? CMD_RANGE_S : (k == 6) ? CMD_RANGE_T : CMD_RANGE_U);
    end
    if ($urandom_range(6) == 0) begin
      send_byte(8'($urandom_range(255)));
    end
    if ($urandom_range(9) != 0) begin
      r = $urandom_range(9);
      send_adc((r == 0) ? 8'h00 : (r == 1) ? 8'h01 : (r == 2) ? 8'hFF : 8'($urandom_range(255)));
    end
  endtask

  task automatic send_number_text();
    int r;
    int digits;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(2, 1)) begin
        send_byte(($urandom_range(2) == 0) ? CHR_SPACE : 8'($urandom_range(CHR_CR, CHR_TAB)));
      end
    end
    if ($urandom_range(7) == 0) begin
      send_byte(CHR_NUL);
    end
    r = $urandom_range(9);
    if (r < 4) begin
      send_byte(CHR_MINUS);
    end else if (r < 6) begin
      send_byte(CHR_PLUS);
    end
    digits = ($urandom_range(9) == 0) ? $urandom_range(7, 4) : $urandom_range(3);
    repeat (digits) begin
      send_byte(CHR_ZERO + 8'($urandom_range(9)));
    end
    if ($urandom_range(7) == 0) begin
      send_byte(8'($urandom_range(126, 32)));
    end
  endtask

  task automatic send_motor_text();
    if ($urandom_range(19) != 0) begin
      send_byte(CMD_TEXT_START);
    end
    send_number_text();
    if ($urandom_range(19) != 0) begin
      send_byte(CMD_SECOND_FIELD);
    end
    send_number_text();
    if ($urandom_range(19) != 0) begin
      send_byte(CMD_MOTOR_END);
    end
  endtask

  task automatic test_sensor_requests();
    send_byte(CMD_ECHO_FIRST);
    send_adc(8'hFF);
    send_byte(CMD_RANGE_S);
    send_adc(8'h00);
    send_byte(CMD_RANGE_T);
    send_adc(8'h01);
    send_adc(8'h00);
    send_byte(CMD_ECHO_LAST);
    send_byte(CMD_RANGE_U);
    send_adc(8'hFF);
    send_byte(CMD_ECHO_FIRST + 8'd2);
    send_byte("x");
    send_adc(8'h80);
  endtask

  task automatic test_motor_commands();
    send_text("m-7#9!");
    send_text("!");
    send_text("m5!");
  endtask

  task automatic test_distance_limit();
    write_limit('0);
    send_byte(CMD_RANGE_S);
    send_adc(8'h01);
    send_byte(CMD_RANGE_U);
    send_adc(8'h00);
    write_limit('1);
    send_byte(CMD_RANGE_T);
    send_adc(8'h01);
    send_byte(CMD_RANGE_S);
    send_adc(8'h00);
    write_limit(LIMIT_RESET);
  endtask

  task automatic test_random_traffic();
    int phase;
    int target;
    int r;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 77;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 77;
        end
        default: begin
          gap_pct = 25;
          stall_pct = 25;
        end
      endcase
      if (phase == 1) begin
        write_limit('0);
      end else if (phase == 2) begin
        write_limit('1);
      end else if (phase == PHASES - 1) begin
        write_limit(LIMIT_RESET);
      end else if (phase > 0) begin
        write_limit(LIMIT_W'($urandom_range(1023)));
      end
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (r < 45) begin
          send_request_sequence();
        end else if (r < 85) begin
          send_motor_text();
        end else if (r < 92) begin
          send_byte(8'($urandom_range(255)));
        end else begin
          send_adc(8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    int x;
    range_table[0] = '0;
    for (x = 1; x < 256; x++) begin
      range_table[x] = range_of(32'(x));
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sensor_requests();
    test_motor_commands();
    test_distance_limit();
    test_random_traffic();
    wait_until_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== serial_sensor_motor_command_decoder_core.f =====
design/ssmcd_pkg.sv
design/ssmcd_queue.sv
design/ssmcd_front.sv
design/ssmcd_back.sv
design/serial_sensor_motor_command_decoder_core.sv
bench/testbench.sv
